[design/bds_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Types and constants shared by the binned delay statistics block.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic CFG_SAMPLING_PERIOD = 1'b0;
  localparam logic CFG_BIN_COUNT       = 1'b1;

  localparam logic [30:0] PERIOD_RESET    = 31'd1000000;
  localparam logic [8:0]  BIN_COUNT_RESET = 9'd256;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 184;

  typedef struct packed {
    logic [31:0] delay_max;
    logic [31:0] delay_min;
    logic [63:0] delay_total;
    logic [31:0] packet_count;
  } bin_t;

  localparam bin_t BIN_EMPTY = '{
    delay_max:    32'd0,
    delay_min:    32'hFFFF_FFFF,
    delay_total:  64'd0,
    packet_count: 32'd0
  };

  typedef struct packed {
    logic        op;
    logic        clear;
    logic        in_range;
    logic [7:0]  bin_index;
    logic [8:0]  bins_used;
    logic [31:0] delay;
  } issue_t;

endpackage
`default_nettype wire

[design/bds_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ram
// Generic single-clock RAM, one write port and one read port, registered
// read that returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/bds_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ctrl
// Configuration registers, bin sequencing and memory read issue.
// ----------------------------------------------------------------------------
module bds_ctrl #(
  parameter int BINS = 256,
  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_write,
  input  wire logic           cfg_index,
  input  wire logic [30:0]    cfg_data,
  input  wire logic           accept,
  input  wire logic           operation,
  input  wire logic [31:0]    now_count,
  input  wire logic [31:0]    sent_count,
  input  wire logic [7:0]     read_bin,
  output bds_pkg::issue_t     issue,
  output logic      [BW-1:0]  rd_addr
);
  import bds_pkg::*;

  logic [30:0]   period_r;
  logic [8:0]    bin_count_r;
  logic          started_r, started_nxt;
  logic [31:0]   next_point_r, next_point_nxt;
  logic [BW-1:0] cur_bin_r, cur_bin_nxt;

  logic [16:0] bins17, n17, last17, cur17, new17, rb17, cur_p1, new_p1;
  logic [31:0] diff_d, diff_e;
  logic        passed, advance, rd_valid, is_record;

  always_comb begin
    bins17 = 17'(BINS);
    n17    = (bin_count_r == 9'd0) ? 17'd1 : {8'd0, bin_count_r};
    if (n17 > bins17) begin
      n17 = bins17;
    end
    last17 = n17 - 17'd1;
    cur17  = 17'(cur_bin_r);
    diff_d = now_count - next_point_r;
    diff_e = next_point_r - now_count;
    if (next_point_r < now_count && diff_d[31]) begin
      passed = 1'b0;
    end else if (diff_e[31]) begin
      passed = 1'b1;
    end else begin
      passed = now_count > next_point_r;
    end

    is_record      = operation == OP_RECORD;
    started_nxt    = started_r;
    next_point_nxt = next_point_r;
    cur_bin_nxt    = cur_bin_r;
    advance        = 1'b0;
    if (accept && is_record) begin
      if (started_r) begin
        if (passed) begin
          next_point_nxt = next_point_r + {1'b0, period_r};
          if (cur17 < last17) begin
            cur_bin_nxt = cur_bin_r + BW'(1);
            advance     = 1'b1;
          end
        end
      end else begin
        next_point_nxt = now_count + {1'b0, period_r};
        started_nxt    = 1'b1;
      end
    end

    new17    = 17'(cur_bin_nxt);
    new_p1   = new17 + 17'd1;
    cur_p1   = cur17 + 17'd1;
    rb17     = {9'd0, read_bin};
    rd_valid = (rb17 <= cur17) && (rb17 < bins17);

    issue.op    = operation;
    issue.delay = now_count - sent_count;
    if (is_record) begin
      issue.clear     = advance || !started_r;
      issue.in_range  = 1'b1;
      issue.bin_index = new17[7:0];
      issue.bins_used = new_p1[8:0];
      rd_addr         = cur_bin_nxt;
    end else begin
      issue.clear     = !started_r;
      issue.in_range  = rd_valid;
      issue.bin_index = read_bin;
      issue.bins_used = cur_p1[8:0];
      rd_addr         = rb17[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RESET;
      bin_count_r  <= BIN_COUNT_RESET;
      started_r    <= 1'b0;
      next_point_r <= 32'd0;
      cur_bin_r    <= '0;
    end else begin
      if (cfg_write && cfg_index == CFG_SAMPLING_PERIOD) begin
        period_r <= cfg_data;
      end
      if (cfg_write && cfg_index == CFG_BIN_COUNT) begin
        bin_count_r <= cfg_data[8:0];
      end
      started_r    <= started_nxt;
      next_point_r <= next_point_nxt;
      cur_bin_r    <= cur_bin_nxt;
    end
  end

endmodule
`default_nettype wire

[design/bds_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bds_update
// Read-modify-write stage with write forwarding, and the output register.
// ----------------------------------------------------------------------------
module bds_update #(
  parameter int BINS = 256,
  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire bds_pkg::issue_t                       issue,
  input  wire logic      [BW-1:0]                    rd_addr,
  input  wire bds_pkg::bin_t                         ram_rdata,
  output logic                                       s1_ready,
  output logic                                       wr_en,
  output logic           [BW-1:0]                    wr_addr,
  output bds_pkg::bin_t                              wr_data,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic           [bds_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                       out_tuser
);
  import bds_pkg::*;

  logic          s1_valid_r;
  issue_t        s1_r;
  logic [BW-1:0] s1_addr_r;
  logic          wb_valid_r;
  logic [BW-1:0] wb_addr_r;
  bin_t          wb_data_r;
  logic          out_valid_r, out_rec_r, out_in_range_r;
  logic [7:0]    out_index_r;
  logic [8:0]    out_used_r;
  bin_t          out_bin_r, out_bin_nxt;
  bin_t          base, upd;
  logic          s1_go, s1_rec;

  always_comb begin
    s1_go    = !out_valid_r || out_tready;
    s1_ready = !s1_valid_r || s1_go;
    s1_rec   = s1_r.op == OP_RECORD;
    if (s1_r.clear) begin
      base = BIN_EMPTY;
    end else if (wb_valid_r && wb_addr_r == s1_addr_r) begin
      base = wb_data_r;
    end else begin
      base = ram_rdata;
    end
    upd.packet_count = base.packet_count + 32'd1;
    upd.delay_total  = base.delay_total + {32'd0, s1_r.delay};
    upd.delay_min    = (s1_r.delay < base.delay_min) ? s1_r.delay : base.delay_min;
    upd.delay_max    = (s1_r.delay > base.delay_max) ? s1_r.delay : base.delay_max;
    if (s1_rec) begin
      out_bin_nxt = upd;
    end else if (s1_r.in_range) begin
      out_bin_nxt = base;
    end else begin
      out_bin_nxt = '0;
    end
    wr_en   = s1_valid_r && s1_go && s1_rec;
    wr_addr = s1_addr_r;
    wr_data = upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= accept;
      end
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
      if (wr_en) begin
        wb_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= issue;
      s1_addr_r <= rd_addr;
    end
    if (wr_en) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= upd;
    end
    if (s1_go && s1_valid_r) begin
      out_bin_r      <= out_bin_nxt;
      out_rec_r      <= s1_rec;
      out_in_range_r <= s1_r.in_range;
      out_index_r    <= s1_r.bin_index;
      out_used_r     <= s1_r.bins_used;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_in_range_r;
  assign out_tdata  = {7'd0, out_used_r, out_bin_r.delay_max, out_bin_r.delay_min,
                       out_bin_r.delay_total, out_bin_r.packet_count, out_index_r};

`ifndef SYNTHESIS
  a_rec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r |-> out_in_range_r)
    else $error("record result without in_range");
  a_rec_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r |-> out_bin_r.delay_min <= out_bin_r.delay_max)
    else $error("record result with min above max");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_in_range_r |-> out_bin_r == '0)
    else $error("out-of-range read with nonzero statistics");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_addr_r))
    else $error("update stage lost its word while stalled");
`endif

endmodule
`default_nettype wire

[design/binned_delay_statistics.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binned_delay_statistics
// Per-bin packet delay statistics kept in a bin memory.
// ----------------------------------------------------------------------------
// The in_ channel takes one word per cycle while in_tready is high: a record
// word (in_tuser low) adds the delay now_count - sent_count to the current
// time bin, a read word (in_tuser high) returns the bin named by read_bin.
// Every word gives exactly one out_ word, in order, passing through the update
// stage register and then the output register.
// The rate is one word per cycle while the output is not stalled, set by the
// read-modify-write of the bin memory: one read and one write per cycle, with
// the last write forwarded into the update stage.
// The cfg_ channel writes sampling_period (index 0) or bin_count (index 1)
// and is always ready; write it only while the block is idle.
// Reset clears the bin sequencer and the pipeline; there is no clearing pass
// over the memory, bin zero reads as empty until the first record.
// When out_tready is low, the output word holds, one more word waits in the
// update stage, and in_tready drops.
// ----------------------------------------------------------------------------
module binned_delay_statistics #(
  parameter int BINS = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [30:0]                          cfg_data,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [31:0] now_count, [63:32] sent_count, [71:64] read_bin
  input  wire logic [bds_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] operation
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [7:0] bin_index, [39:8] packet_count, [103:40] delay_total,
  // [135:104] delay_min, [167:136] delay_max, [176:168] bins_used, rest zero
  output logic      [bds_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] in_range
  output logic                                      out_tuser
);
  import bds_pkg::*;

  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;

  logic          accept, cfg_write, wr_en;
  issue_t        issue;
  logic [BW-1:0] rd_addr, wr_addr;
  bin_t          ram_rdata, wr_data;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = in_tvalid && in_tready;

  bds_ctrl #(.BINS(BINS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .operation  (in_tuser),
    .now_count  (in_tdata[31:0]),
    .sent_count (in_tdata[63:32]),
    .read_bin   (in_tdata[71:64]),
    .issue      (issue),
    .rd_addr    (rd_addr)
  );

  bds_ram #(.WIDTH($bits(bin_t)), .DEPTH(BINS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  bds_update #(.BINS(BINS)) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .issue      (issue),
    .rd_addr    (rd_addr),
    .ram_rdata  (ram_rdata),
    .s1_ready   (in_tready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
